### rtl/gaussian_pin_force_macros.svh
`ifndef GAUSSIAN_PIN_FORCE_MACROS_SVH
`define GAUSSIAN_PIN_FORCE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define GPF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define GPF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gpf_pkg.sv
`timescale 1ns / 1ps

package gpf_pkg;

    localparam int DATA_W             = 32;
    localparam int LEN_W              = 31;
    localparam int SQ_W               = 2 * LEN_W;
    localparam int QUO_W              = 32;
    localparam int W_W                = 17;
    localparam int FRAC_W             = 16;
    localparam int CFG_IDX_W          = 3;
    localparam int DEF_EXP_TABLE_SIZE = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIN_X    = 3'd0,
        REG_PIN_Y    = 3'd1,
        REG_PIN_Z    = 3'd2,
        REG_SPRING_K = 3'd3,
        REG_WIDTH_L  = 3'd4,
        REG_BOX_LX   = 3'd5,
        REG_BOX_LY   = 3'd6
    } t_reg_idx;

    // Per-item data that rides alongside the distance and weight path.
    typedef struct packed {
        logic              last;
        logic              zero;
        logic              neg;
        logic [DATA_W-1:0] ak;
        logic [DATA_W:0]   adh;
        logic [DATA_W-1:0] force_in;
    } t_side;

    // exp(-16 f / 2^32) in Q1.16: Taylor series of exp(-f) in Q1.31, then squared four times.
    function automatic logic [W_W-1:0] gpf_exp_entry(input logic [63:0] f);
        logic [63:0] plus;
        logic [63:0] minus;
        logic [63:0] term;
        logic [63:0] e;
        plus  = 64'h8000_0000;
        minus = '0;
        term  = 64'h8000_0000;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * f) >> 32) / 64'(k);
            if (k[0]) begin
                minus = minus + term;
            end else begin
                plus = plus + term;
            end
        end
        if (minus >= plus) begin
            e = '0;
        end else begin
            e = plus - minus;
            if (e > 64'h8000_0000) begin
                e = 64'h8000_0000;
            end
        end
        for (int s = 0; s < 4; s++) begin
            e = (e * e + 64'h4000_0000) >> 31;
        end
        return W_W'((e + 64'd16384) >> 15);
    endfunction

endpackage

### rtl/gaussian_pin_force.sv
`timescale 1ns / 1ps
// Channel   Direction  Word
// s_axis    in         tdata = pos_x, pos_y, height, force_in; tlast = last_point
// m_axis    out        tdata = force_out; tlast = last_out
// cfg       in         i_cfg_index selects register, i_cfg_data carries its value
//
// One point enters per cycle unless the output stalls; the path includes the one-bit-per-stage
// divider that forms the squared distance over l^2.
// Reset is synchronous and active low; it clears all stage valid bits and sets the config registers to their defaults.
// The whole pipeline advances together; it halts only while a finished word is
// waiting at the output, and then s_axis_tready falls. The cfg port is always ready.

`include "gaussian_pin_force_macros.svh"

module gaussian_pin_force import gpf_pkg::*; #(
    parameter int EXP_TABLE_SIZE = DEF_EXP_TABLE_SIZE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [4*DATA_W-1:0]  s_axis_tdata,  // pos_x, pos_y, height, force_in from bit 0
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,  // force_out
    output logic                 m_axis_tlast
);

    localparam int IDX_W = $clog2(EXP_TABLE_SIZE + 1);
    localparam int P_W   = QUO_W + IDX_W;
    localparam logic [IDX_W-1:0] TBL_SIZE = IDX_W'(EXP_TABLE_SIZE);
    localparam logic [IDX_W-1:0] TBL_LAST = IDX_W'(EXP_TABLE_SIZE - 1);
    localparam logic [W_W-1:0]   W_ONE    = W_W'(1) << FRAC_W;
    localparam logic signed [49:0] RES_MAX = 50'sd2147483647;
    localparam logic signed [49:0] RES_MIN = -50'sd2147483648;

    // Configuration registers.
    logic signed [DATA_W-1:0] r_pin_x, r_pin_y, r_pin_z, r_spring_k;
    logic [LEN_W-1:0]         r_width_l, r_box_lx, r_box_ly;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_x    <= '0;
            r_pin_y    <= '0;
            r_pin_z    <= '0;
            r_spring_k <= '0;
            r_width_l  <= LEN_W'(65536);
            r_box_lx   <= LEN_W'(65536);
            r_box_ly   <= LEN_W'(65536);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PIN_X:    r_pin_x    <= i_cfg_data;
                REG_PIN_Y:    r_pin_y    <= i_cfg_data;
                REG_PIN_Z:    r_pin_z    <= i_cfg_data;
                REG_SPRING_K: r_spring_k <= i_cfg_data;
                REG_WIDTH_L:  r_width_l  <= i_cfg_data[LEN_W-1:0];
                REG_BOX_LX:   r_box_lx   <= i_cfg_data[LEN_W-1:0];
                REG_BOX_LY:   r_box_ly   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Weight table, entry i = exp(-16 i / EXP_TABLE_SIZE) in Q1.16.
    logic [W_W-1:0] w_tab [EXP_TABLE_SIZE+1];
    for (genvar g = 0; g <= EXP_TABLE_SIZE; g++) begin : g_tab
        localparam logic [63:0] ARG = (64'(g) << 32) / 64'(EXP_TABLE_SIZE);
        assign w_tab[g] = gpf_exp_entry(ARG);
    end

    function automatic logic signed [35:0] wrap_axis(input logic signed [32:0] r,
                                                     input logic [LEN_W-1:0] len);
        logic signed [35:0] v;
        logic signed [35:0] l;
        v = 36'(r);
        l = signed'(36'(len));
        if ((v <<< 1) > l) begin
            v = v - l;
        end
        if ((v <<< 1) < -l) begin
            v = v + l;
        end
        return v;
    endfunction

    logic w_en;
    logic r_out_vld;
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    // Stage 1: offsets from the pin.
    logic               r_s1_vld, r_s1_last;
    logic signed [32:0] r_s1_rx, r_s1_ry, r_s1_dh;
    logic [DATA_W-1:0]  r_s1_force;
    logic signed [DATA_W-1:0] w_pos_x, w_pos_y, w_height;

    assign w_pos_x  = signed'(s_axis_tdata[DATA_W-1:0]);
    assign w_pos_y  = signed'(s_axis_tdata[2*DATA_W-1:DATA_W]);
    assign w_height = signed'(s_axis_tdata[3*DATA_W-1:2*DATA_W]);

    // Stage 2: minimum image, magnitudes for the spring term.
    logic               r_s2_vld;
    logic signed [35:0] r_s2_rx, r_s2_ry;
    t_side              r_s2_side, w_s2_side;

    always_comb begin
        w_s2_side.last     = r_s1_last;
        w_s2_side.zero     = 1'b0;
        w_s2_side.neg      = r_spring_k[DATA_W-1] ^ r_s1_dh[32];
        w_s2_side.ak       = r_spring_k[DATA_W-1] ? DATA_W'(-33'(r_spring_k))
                                                  : DATA_W'(r_spring_k);
        w_s2_side.adh      = r_s1_dh[32] ? 33'(-34'(r_s1_dh)) : 33'(r_s1_dh);
        w_s2_side.force_in = r_s1_force;
    end

    // Stage 3: absolute offsets, early out when outside the width.
    logic               r_s3_vld;
    logic [LEN_W-1:0]   r_s3_ax, r_s3_ay;
    t_side              r_s3_side, w_s3_side;
    logic [35:0]        w_ax, w_ay;

    always_comb begin
        w_ax = r_s2_rx[35] ? 36'(-r_s2_rx) : 36'(r_s2_rx);
        w_ay = r_s2_ry[35] ? 36'(-r_s2_ry) : 36'(r_s2_ry);
        w_s3_side      = r_s2_side;
        w_s3_side.zero = (w_ax >= 36'(r_width_l)) || (w_ay >= 36'(r_width_l));
    end

    // Stage 4: squares.
    logic               r_s4_vld;
    logic [SQ_W-1:0]    r_s4_sx, r_s4_sy, r_s4_l2;
    t_side              r_s4_side;

    // Stage 5: squared distance and the test against l^2.
    logic               r_s5_vld;
    logic [SQ_W-1:0]    r_s5_s, r_s5_l2;
    t_side              r_s5_side, w_s5_side;
    logic [SQ_W:0]      w_s5_sum;

    always_comb begin
        w_s5_sum       = (SQ_W+1)'(r_s4_sx) + (SQ_W+1)'(r_s4_sy);
        w_s5_side      = r_s4_side;
        w_s5_side.zero = r_s4_side.zero || (w_s5_sum >= (SQ_W+1)'(r_s4_l2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= s_axis_tvalid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_rx    <= 33'(w_pos_x) - 33'(r_pin_x);
            r_s1_ry    <= 33'(w_pos_y) - 33'(r_pin_y);
            r_s1_dh    <= 33'(w_height) - 33'(r_pin_z);
            r_s1_force <= s_axis_tdata[4*DATA_W-1:3*DATA_W];
            r_s1_last  <= s_axis_tlast;
            r_s2_rx    <= wrap_axis(r_s1_rx, r_box_lx);
            r_s2_ry    <= wrap_axis(r_s1_ry, r_box_ly);
            r_s2_side  <= w_s2_side;
            r_s3_ax    <= w_ax[LEN_W-1:0];
            r_s3_ay    <= w_ay[LEN_W-1:0];
            r_s3_side  <= w_s3_side;
            r_s4_sx    <= SQ_W'(r_s3_ax) * SQ_W'(r_s3_ax);
            r_s4_sy    <= SQ_W'(r_s3_ay) * SQ_W'(r_s3_ay);
            r_s4_l2    <= SQ_W'(r_width_l) * SQ_W'(r_width_l);
            r_s4_side  <= r_s3_side;
            r_s5_s     <= w_s5_sum[SQ_W-1:0];
            r_s5_l2    <= r_s4_l2;
            r_s5_side  <= w_s5_side;
        end
    end

    logic             w_dv_vld;
    logic [QUO_W-1:0] w_dv_quo;
    t_side            w_dv_side;

    gpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s5_vld),
        .i_num   (r_s5_s),
        .i_den   (r_s5_l2),
        .i_side  (r_s5_side),
        .o_vld   (w_dv_vld),
        .o_quo   (w_dv_quo),
        .o_side  (w_dv_side)
    );

    // Stage 6: table position.
    logic             r_s6_vld;
    logic [P_W-1:0]   r_s6_p;
    t_side            r_s6_side;

    // Stage 7: table reads.
    logic             r_s7_vld;
    logic [W_W-1:0]   r_s7_e0, r_s7_e1;
    logic [FRAC_W-1:0] r_s7_frac;
    t_side            r_s7_side;
    logic [IDX_W-1:0] w_idx, w_idx_n;

    always_comb begin
        w_idx   = (r_s6_p[P_W-1:QUO_W] >= TBL_SIZE) ? TBL_LAST : r_s6_p[P_W-1:QUO_W];
        w_idx_n = w_idx + IDX_W'(1);
    end

    // Stage 8: interpolation product; stage 9: weight.
    logic             r_s8_vld;
    logic [W_W-1:0]   r_s8_e0;
    logic [W_W+FRAC_W-1:0] r_s8_dp;
    t_side            r_s8_side;
    logic             r_s9_vld;
    logic [W_W-1:0]   r_s9_w;
    t_side            r_s9_side;

    // Stages 10 to 12: |k| * w * |h - z| rounded to Q16.16.
    logic             r_s10_vld;
    logic [47:0]      r_s10_a;
    t_side            r_s10_side;
    logic             r_s11_vld;
    logic [63:0]      r_s11_p0;
    logic [64:0]      r_s11_p1;
    t_side            r_s11_side;
    logic             r_s12_vld;
    logic [47:0]      r_s12_mag;
    t_side            r_s12_side;
    logic [79:0]      w_s12_sum;

    assign w_s12_sum = (80'(r_s11_p1) << 16) + 80'(r_s11_p0) + 80'h8000_0000;

    // Output stage: signed add and saturation.
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;
    logic signed [49:0] w_mag_s, w_res;
    logic [DATA_W-1:0]  w_sat;

    always_comb begin
        w_mag_s = signed'(50'(r_s12_mag));
        w_res   = 50'(signed'(r_s12_side.force_in)) + (r_s12_side.neg ? -w_mag_s : w_mag_s);
        priority if (w_res > RES_MAX) begin
            w_sat = DATA_W'(RES_MAX);
        end else if (w_res < RES_MIN) begin
            w_sat = DATA_W'(RES_MIN);
        end else begin
            w_sat = w_res[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_s12_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s6_vld  <= w_dv_vld;
            r_s7_vld  <= r_s6_vld;
            r_s8_vld  <= r_s7_vld;
            r_s9_vld  <= r_s8_vld;
            r_s10_vld <= r_s9_vld;
            r_s11_vld <= r_s10_vld;
            r_s12_vld <= r_s11_vld;
            r_out_vld <= r_s12_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_p     <= P_W'(w_dv_quo) * P_W'(EXP_TABLE_SIZE);
            r_s6_side  <= w_dv_side;
            r_s7_e0    <= w_tab[w_idx];
            r_s7_e1    <= w_tab[w_idx_n];
            r_s7_frac  <= r_s6_p[QUO_W-1:QUO_W-FRAC_W];
            r_s7_side  <= r_s6_side;
            r_s8_e0    <= r_s7_e0;
            r_s8_dp    <= (W_W+FRAC_W)'(r_s7_e0 - r_s7_e1) * (W_W+FRAC_W)'(r_s7_frac);
            r_s8_side  <= r_s7_side;
            r_s9_w     <= r_s8_side.zero ? '0 : r_s8_e0 - r_s8_dp[W_W+FRAC_W-1:FRAC_W];
            r_s9_side  <= r_s8_side;
            r_s10_a    <= 48'(r_s9_side.ak) * 48'(r_s9_w);
            r_s10_side <= r_s9_side;
            r_s11_p0   <= 64'(r_s10_a) * 64'(r_s10_side.adh[15:0]);
            r_s11_p1   <= 65'(r_s10_a) * 65'(r_s10_side.adh[32:16]);
            r_s11_side <= r_s10_side;
            r_s12_mag  <= w_s12_sum[79:32];
            r_s12_side <= r_s11_side;
            r_out_data <= w_sat;
            r_out_last <= r_s12_side.last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    `GPF_ASSERT_IMP(a_stall_holds_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")
    `GPF_ASSERT_NXT(a_stall_holds_mag, !w_en && r_s12_vld, $stable(r_s12_mag) && r_s12_vld, "stalled stage changed")
    `GPF_ASSERT_IMP(a_weight_range, r_s9_vld, r_s9_w <= W_ONE, "weight above one")

endmodule

### rtl/gpf_div.sv
`timescale 1ns / 1ps

module gpf_div import gpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [SQ_W-1:0]  i_num,
    input  logic [SQ_W-1:0]  i_den,
    input  t_side            i_side,
    output logic             o_vld,
    output logic [QUO_W-1:0] o_quo,
    output t_side            o_side
);

    // One quotient bit per stage; exact only for a numerator below the divisor.
    logic             r_vld  [QUO_W];
    logic [SQ_W-1:0]  r_rem  [QUO_W];
    logic [SQ_W-1:0]  r_den  [QUO_W];
    logic [QUO_W-1:0] r_quo  [QUO_W];
    t_side            r_side [QUO_W];

    for (genvar g = 0; g < QUO_W; g++) begin : g_step
        logic             w_vld;
        logic [SQ_W-1:0]  w_rem;
        logic [SQ_W-1:0]  w_den;
        logic [QUO_W-1:0] w_quo;
        t_side            w_side;
        logic [SQ_W:0]    w_sh;
        logic             w_ge;

        if (g == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_den  = r_den[g-1];
            assign w_quo  = r_quo[g-1];
            assign w_side = r_side[g-1];
        end

        assign w_sh = {w_rem, 1'b0};
        assign w_ge = (w_sh >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= w_ge ? SQ_W'(w_sh - {1'b0, w_den}) : SQ_W'(w_sh);
                r_den[g]  <= w_den;
                r_quo[g]  <= {w_quo[QUO_W-2:0], w_ge};
                r_side[g] <= w_side;
            end
        end
    end

    assign o_vld  = r_vld[QUO_W-1];
    assign o_quo  = r_quo[QUO_W-1];
    assign o_side = r_side[QUO_W-1];

endmodule

### verif/gaussian_pin_force_tb.sv
`timescale 1ns / 1ps

module gaussian_pin_force_tb;
    import gpf_pkg::*;

    localparam int  N_TAB     = DEF_EXP_TABLE_SIZE;
    localparam int  LAT       = 60;
    localparam longint LIMIT  = 600000;

    typedef struct {
        logic [31:0] force_val;
        logic        last;
    } t_force_exp;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] h;
        logic [31:0] f;
        logic        last;
        logic        typed;
        logic [31:0] exp_force;
    } t_point_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [4*DATA_W-1:0] s_axis_tdata = '0;  // pos_x, pos_y, height, force_in from bit 0
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;  // force_out
    logic m_axis_tlast;

    gaussian_pin_force dut (.*);

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block's registers and its weight table.
    longint pin_x_m, pin_y_m, pin_z_m, spring_k_m, width_m, box_x_m, box_y_m;
    longint unsigned weight_rom [0:N_TAB];

    t_force_exp force_q [$];
    t_point_row rows [$];
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  rx_hold = 1'b0;
    int  errors = 0;
    int  n_points = 0;
    int  n_forces = 0;
    int  n_weighted = 0;
    longint cycles = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch on word %0d: %s got %h expected %h", n_forces, what, got, want);
    endtask

    function automatic void build_weight_rom();
        longint unsigned arg, pos_sum, neg_sum, term, e;
        for (int i = 0; i <= N_TAB; i++) begin
            arg = (longint'(i) << 32) / N_TAB;
            pos_sum = 64'h8000_0000;
            neg_sum = 0;
            term = 64'h8000_0000;
            for (int n = 1; n <= 24; n++) begin
                term = ((term * arg) >> 32) / n;
                if (n % 2 == 1) neg_sum += term;
                else pos_sum += term;
            end
            if (neg_sum >= pos_sum) begin
                e = 0;
            end else begin
                e = pos_sum - neg_sum;
                if (e > 64'h8000_0000) e = 64'h8000_0000;
            end
            repeat (4) e = (e * e + 64'h4000_0000) >> 31;
            weight_rom[i] = (e + 16384) >> 15;
        end
    endfunction

    function automatic longint wrap_offset(input longint r, input longint len);
        if (2 * r > len) r -= len;
        if (2 * r < -len) r += len;
        return r;
    endfunction

    function automatic longint unsigned gauss_weight(input longint rx, input longint ry);
        longint unsigned ax, ay, l, l2, s, idx, frac, e0, e1;
        logic [127:0] q, p;
        ax = rx < 0 ? -rx : rx;
        ay = ry < 0 ? -ry : ry;
        l = width_m;
        if (ax >= l || ay >= l) return 0;
        l2 = l * l;
        s = ax * ax + ay * ay;
        if (s >= l2) return 0;
        q = {32'h0, s, 32'h0} / {64'h0, l2};
        p = q * N_TAB;
        idx = p[95:32];
        if (idx >= N_TAB) idx = N_TAB - 1;
        frac = p[31:16];
        e0 = weight_rom[idx];
        e1 = weight_rom[idx + 1];
        return e0 - (((e0 - e1) * frac) >> 16);
    endfunction

    function automatic logic [31:0] pin_force(input logic [31:0] px, input logic [31:0] py,
                                              input logic [31:0] h, input logic [31:0] f);
        longint rx, ry, dh, res;
        longint unsigned w, ak, adh;
        logic [127:0] prod;
        bit neg;
        rx = wrap_offset(longint'($signed(px)) - pin_x_m, box_x_m);
        ry = wrap_offset(longint'($signed(py)) - pin_y_m, box_y_m);
        w = gauss_weight(rx, ry);
        if (w != 0) n_weighted++;
        dh = longint'($signed(h)) - pin_z_m;
        ak = spring_k_m < 0 ? -spring_k_m : spring_k_m;
        adh = dh < 0 ? -dh : dh;
        neg = (spring_k_m < 0) != (dh < 0);
        prod = (128'(ak) * 128'(w) * 128'(adh) + 128'h8000_0000) >> 32;
        res = longint'($signed(f)) + (neg ? -longint'(prod[63:0]) : longint'(prod[63:0]));
        if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
        if (res < -64'sh8000_0000) res = -64'sh8000_0000;
        return res[31:0];
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        unique case (idx)
            REG_PIN_X:    pin_x_m = longint'($signed(val));
            REG_PIN_Y:    pin_y_m = longint'($signed(val));
            REG_PIN_Z:    pin_z_m = longint'($signed(val));
            REG_SPRING_K: spring_k_m = longint'($signed(val));
            REG_WIDTH_L:  width_m = val[30:0];
            REG_BOX_LX:   box_x_m = val[30:0];
            REG_BOX_LY:   box_y_m = val[30:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_all(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
                           input logic [31:0] k, input logic [31:0] l, input logic [31:0] bx,
                           input logic [31:0] by);
        write_reg(REG_PIN_X, px);
        write_reg(REG_PIN_Y, py);
        write_reg(REG_PIN_Z, pz);
        write_reg(REG_SPRING_K, k);
        write_reg(REG_WIDTH_L, l);
        write_reg(REG_BOX_LX, bx);
        write_reg(REG_BOX_LY, by);
    endtask

    task automatic wait_drained();
        while (force_q.size() != 0) @(posedge i_clk);
        repeat (LAT) @(negedge i_clk);
    endtask

    // Drives one word and records its expected force once the block has taken it.
    task automatic send_point(input t_point_row r);
        t_force_exp e;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {r.f, r.h, r.py, r.px};
        s_axis_tlast = r.last;
        do @(posedge i_clk); while (!s_axis_tready);
        e.force_val = pin_force(r.px, r.py, r.h, r.f);
        if (r.typed) e.force_val = r.exp_force;
        e.last = r.last;
        force_q.push_back(e);
        n_points++;
    endtask

    task automatic add_row(input logic [31:0] px, input logic [31:0] py, input logic [31:0] h,
                           input logic [31:0] f, input logic last, input logic typed,
                           input logic [31:0] ef);
        t_point_row r;
        r = '{px, py, h, f, last, typed, ef};
        rows.push_back(r);
    endtask

    task automatic run_rows();
        foreach (rows[i]) send_point(rows[i]);
        rows.delete();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Positions mostly near the pin, sometimes one box length away, otherwise anywhere.
    function automatic logic [31:0] near_pos(input longint pin, input longint box);
        longint span, off;
        int pick;
        pick = $urandom_range(9);
        span = width_m + width_m / 4 + 1;
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        off = longint'($urandom_range(32'(span))) * ($urandom_range(1) ? 1 : -1);
        if (pick < 6) return 32'(pin + off);
        if (pick < 8) return 32'(pin + off + ($urandom_range(1) ? box : -box));
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_len();
        unique case ($urandom_range(5))
            0: return 32'd1;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(32'h0010_0000, 32'd1024);
            default: return $urandom;
        endcase
    endfunction

    always @(negedge i_clk) m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    always @(posedge i_clk) begin
        t_force_exp e;
        cycles++;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (force_q.size() == 0) begin
                report("unexpected word", m_axis_tdata, 32'h0);
            end else begin
                e = force_q.pop_front();
                if (m_axis_tdata !== e.force_val) report("force_out", m_axis_tdata, e.force_val);
                if (m_axis_tlast !== e.last) report("last_out", 32'(m_axis_tlast), 32'(e.last));
            end
            n_forces++;
        end
        if (cycles > LIMIT) begin
            $display("timeout with %0d words outstanding", force_q.size());
            $display("gaussian_pin_force regression: fail");
            $finish;
        end
    end

    initial begin
        t_point_row r;
        build_weight_rom();
        pin_x_m = 0; pin_y_m = 0; pin_z_m = 0; spring_k_m = 0;
        width_m = 65536; box_x_m = 65536; box_y_m = 65536;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Out of reset the spring constant is zero, so the force passes through.
        add_row(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF);
        add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1,
                32'h8000_0000);
        add_row(32'h0, 32'h0, 32'h1234_5678, 32'h0, 1'b0, 1'b1, 32'h0);
        run_rows();
        wait_drained();

        // Unit spring: full weight at the pin, where large height offsets saturate; later rows sit off the pin.
        set_all(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0004_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF);
        add_row(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF);
        add_row(32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000);
        add_row(32'h0, 32'h0, 32'h0001_0000, 32'h0, 1'b0, 1'b1, 32'h0001_0000);
        add_row(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 1'b0, 1'b0, 32'h0);
        add_row(32'h0003_FFFF, 32'h0, 32'h0100_0000, 32'h0, 1'b0, 1'b0, 32'h0);
        add_row(32'h0004_0000, 32'h0, 32'h0100_0000, 32'h5, 1'b0, 1'b1, 32'h5);
        add_row(32'h0002_D413, 32'h0002_D413, 32'h0100_0000, 32'h0, 1'b0, 1'b0, 32'h0);
        add_row(32'hFFFE_0000, 32'h0001_8000, 32'hF000_0000, 32'h7000_0000, 1'b1, 1'b0, 32'h0);
        run_rows();
        wait_drained();

        // Small box wraps offsets; zero width gives no force at all.
        set_all(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h8000_0000, 32'h0,
                32'h0008_0000, 32'h0);
        add_row(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h1234, 1'b1, 1'b1, 32'h1234);
        run_rows();
        wait_drained();
        set_all(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h8000_0000, 32'h0002_0000,
                32'h0008_0000, 32'h0);
        add_row(32'h0008_8000, 32'hFFFF_0000, 32'h0003_0000, 32'h0, 1'b0, 1'b0, 32'h0);
        add_row(32'hFFF9_8000, 32'hFFFF_8000, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0);
        add_row(32'h0005_0000, 32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0);
        run_rows();
        wait_drained();

        for (int blk = 0; blk < 6; blk++) begin
            tx_idle_pct = blk < 2 ? 30 : (blk < 4 ? 62 : 0);
            rx_idle_pct = blk < 2 ? 62 : (blk < 4 ? 30 : 0);
            set_all(blk == 0 ? 32'h7FFF_FFFF : (blk == 1 ? 32'h8000_0000 : $urandom),
                    $urandom, $urandom,
                    blk == 2 ? 32'h7FFF_FFFF : (blk == 3 ? 32'h8000_0000 : $urandom),
                    blk == 5 ? 32'h0010_0000 : pick_len(), pick_len(), pick_len());
            if (blk == 5) begin
                fork
                    begin
                        repeat (20) @(negedge i_clk);
                        rx_hold = 1'b1;
                        repeat (400) @(negedge i_clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            repeat (270) begin
                r.px = near_pos(pin_x_m, box_x_m);
                r.py = near_pos(pin_y_m, box_y_m);
                r.h = $urandom_range(3) == 0 ? $urandom : 32'(pin_z_m + $signed($urandom) / 256);
                r.f = $urandom;
                r.last = $urandom_range(7) == 0;
                r.typed = 1'b0;
                r.exp_force = '0;
                send_point(r);
            end
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            wait_drained();
        end

        $display("sent %0d points under ten register settings and random stalls,",
                 n_points);
        $display("%0d forces returned, %0d of them with a non-zero pin weight", n_forces,
                 n_weighted);
        if (errors == 0 && force_q.size() == 0) begin
            $display("gaussian_pin_force regression: pass");
        end else begin
            $display("gaussian_pin_force regression: fail");
        end
        $finish;
    end

endmodule

### gaussian_pin_force.f
+incdir+rtl
rtl/gpf_pkg.sv
rtl/gpf_div.sv
rtl/gaussian_pin_force.sv
verif/gaussian_pin_force_tb.sv
